[hw/rtl/gsbp_pkg.sv]
package gsbp_pkg;

    // Operation codes carried on func
    localparam int FUNC_W = 3;
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_UPDATE  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_UNCOND  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_BTB_UPD = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_SQUASH  = 3'd4;

    // Global history register and its length register
    localparam int HIST_W = 12;
    localparam int LEN_W  = 4;
    localparam logic [LEN_W-1:0] HIST_LEN_MAX   = 4'd12;
    localparam logic [LEN_W-1:0] HIST_LEN_RESET = 4'd12;

    // Branch address field width
    localparam int ADDR_W = 32;

    // History command from the sequencer
    typedef struct packed {
        logic shift;
        logic shift_bit;
        logic clear;
    } hist_cmd_t;

endpackage

[hw/rtl/gsbp_history.sv]
module gsbp_history
    import gsbp_pkg::*;
#(
    parameter int INDEX_BITS   = 12,
    parameter int ADDRESS_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [LEN_W-1:0]      cfg_len,
    input  logic [ADDR_W-1:0]     br_addr,
    input  hist_cmd_t             cmd,
    output logic [INDEX_BITS-1:0] index
);

    localparam int HIST_EXT = (INDEX_BITS > HIST_W) ? INDEX_BITS : HIST_W;

    logic [LEN_W-1:0]    len_reg;
    logic [HIST_W-1:0]   hist_reg;
    logic [HIST_W-1:0]   hist_next;
    logic [LEN_W-1:0]    eff_len;
    logic [HIST_W-1:0]   hist_mask;
    logic [HIST_W-1:0]   hist_masked;
    logic [HIST_EXT-1:0] hist_ext;
    logic [ADDR_W-1:0]   addr_mask;
    logic [ADDR_W-1:0]   addr_masked;

    // Clamp the length to the register width and build the masks
    always_comb
    begin
        eff_len = (len_reg > HIST_LEN_MAX) ? HIST_LEN_MAX : len_reg;
        for (int i = 0; i < HIST_W; i++)
        begin
            hist_mask[i] = (i < int'(eff_len));
        end
        for (int i = 0; i < ADDR_W; i++)
        begin
            addr_mask[i] = (i < ADDRESS_BITS);
        end
    end

    // Form the table index from address and masked history
    assign hist_masked = hist_reg & hist_mask;
    assign hist_ext    = HIST_EXT'(hist_masked);
    assign addr_masked = br_addr & addr_mask;
    assign index       = addr_masked[INDEX_BITS-1:0] ^ hist_ext[INDEX_BITS-1:0];

    // Shift in an outcome or clear the history
    always_comb
    begin
        priority if (cmd.clear)
        begin
            hist_next = '0;
        end
        else if (cmd.shift)
        begin
            hist_next = {hist_reg[HIST_W-2:0], cmd.shift_bit} & hist_mask;
        end
        else
        begin
            hist_next = hist_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '0;
            len_reg  <= HIST_LEN_RESET;
        end
        else
        begin
            hist_reg <= hist_next;
            if (cfg_we)
            begin
                len_reg <= cfg_len;
            end
        end
    end

endmodule

[hw/rtl/gsbp_counter_table.sv]
module gsbp_counter_table #(
    parameter int INDEX_BITS   = 12,
    parameter int COUNTER_BITS = 2
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    rd_en,
    input  logic [INDEX_BITS-1:0]   rd_addr,
    output logic [COUNTER_BITS-1:0] rd_data,
    input  logic                    wr_en,
    input  logic [INDEX_BITS-1:0]   wr_addr,
    input  logic [COUNTER_BITS-1:0] wr_data,
    output logic                    clearing
);

    localparam int DEPTH = 1 << INDEX_BITS;

    logic [COUNTER_BITS-1:0] mem [DEPTH];
    logic                    clr_active_reg;
    logic [INDEX_BITS-1:0]   clr_addr_reg;
    logic                    mem_we;
    logic [INDEX_BITS-1:0]   mem_waddr;
    logic [COUNTER_BITS-1:0] mem_wdata;

    // Sweep every entry to zero after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (&clr_addr_reg)
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    assign clearing = clr_active_reg;

    // Select the sweep or the user write
    assign mem_we    = clr_active_reg | wr_en;
    assign mem_waddr = clr_active_reg ? clr_addr_reg : wr_addr;
    assign mem_wdata = clr_active_reg ? '0 : wr_data;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hw/rtl/global_history_branch_predictor.sv]
// Channel   Handshake              Payload
// input     start & !busy          func, br_addr, taken
// result    done (one cycle)       prediction
// config    cfg_valid & cfg_ready  cfg_data (history length)
//
// Each item has an accept cycle and a modify stage: the counter table is read in
// the accept cycle and the counter is modified and, for an update, written back in
// the next; busy is high in the modify stage. The result strobe follows in the
// cycle after that, while a new item may already be accepted.
// After reset the table is swept to zero, one entry per cycle, with busy high
// until every entry is cleared; configuration writes are taken throughout.
// The receiver cannot stall: done lasts exactly one cycle.
module global_history_branch_predictor
    import gsbp_pkg::*;
#(
    parameter int INDEX_BITS   = 12,
    parameter int COUNTER_BITS = 2,
    parameter int ADDRESS_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [FUNC_W-1:0] func,
    input  logic [ADDR_W-1:0] br_addr,
    input  logic              taken,
    output logic              done,
    output logic              prediction,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [LEN_W-1:0]  cfg_data
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;
    localparam logic [COUNTER_BITS-1:0] CTR_MAX = '1;

    logic                    state_reg;
    logic                    state_next;
    logic                    accept;
    logic                    clearing;
    logic [INDEX_BITS-1:0]   index;
    hist_cmd_t               hist_cmd;
    logic [FUNC_W-1:0]       func_reg;
    logic                    taken_reg;
    logic [INDEX_BITS-1:0]   idx_reg;
    logic [COUNTER_BITS-1:0] ctr;
    logic [COUNTER_BITS-1:0] ctr_new;
    logic                    wr_en;
    logic                    pred;
    logic                    done_reg;
    logic                    prediction_reg;

    assign busy      = clearing | (state_reg == S_EXEC);
    assign accept    = start & ~busy;
    assign cfg_ready = 1'b1;

    // Decode the history action of an accepted item
    always_comb
    begin
        hist_cmd = '0;
        if (accept)
        begin
            unique case (func)
                FUNC_UPDATE, FUNC_UNCOND:
                begin
                    hist_cmd.shift     = 1'b1;
                    hist_cmd.shift_bit = taken;
                end
                FUNC_BTB_UPD:
                begin
                    hist_cmd.shift = 1'b1;
                end
                FUNC_SQUASH:
                begin
                    hist_cmd.clear = 1'b1;
                end
                default:
                begin
                    hist_cmd = '0;
                end
            endcase
        end
    end

    gsbp_history #(
        .INDEX_BITS   (INDEX_BITS),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_history (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_we  (cfg_valid & cfg_ready),
        .cfg_len (cfg_data),
        .br_addr (br_addr),
        .cmd     (hist_cmd),
        .index   (index)
    );

    gsbp_counter_table #(
        .INDEX_BITS   (INDEX_BITS),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_addr  (index),
        .rd_data  (ctr),
        .wr_en    (wr_en),
        .wr_addr  (idx_reg),
        .wr_data  (ctr_new),
        .clearing (clearing)
    );

    // Saturate the counter and form the prediction
    always_comb
    begin
        if (taken_reg)
        begin
            ctr_new = (ctr == CTR_MAX) ? ctr : ctr + 1'b1;
        end
        else
        begin
            ctr_new = (ctr == '0) ? ctr : ctr - 1'b1;
        end
        wr_en = (state_reg == S_EXEC) && (func_reg == FUNC_UPDATE);
        pred  = (func_reg == FUNC_LOOKUP) && ctr[COUNTER_BITS-1];
    end

    // Advance the sequencer
    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  state_next = accept ? S_EXEC : S_IDLE;
            S_EXEC:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_EXEC);
        end
    end

    // Hold the item fields and the result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= func;
            taken_reg <= taken;
            idx_reg   <= index;
        end
        if (state_reg == S_EXEC)
        begin
            prediction_reg <= pred;
        end
    end

    assign done       = done_reg;
    assign prediction = prediction_reg;

    // An accepted item always reaches the modify stage next
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EXEC))
        else $error("accepted item did not enter modify stage");

    // The modify stage always yields exactly one result strobe
    a_exec_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |=> done_reg)
        else $error("modify stage without result strobe");

    // No table write while the reset sweep runs
    a_no_write_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !wr_en)
        else $error("table write during clearing sweep");

    // Only a lookup may predict taken
    a_pred_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (func_reg != FUNC_LOOKUP)) |-> !prediction_reg)
        else $error("prediction set for a non-lookup item");

endmodule

[dv/gshare_checker.sv]
`timescale 1ns / 1ps

module gshare_checker
    import gsbp_pkg::*;
#(
    parameter int INDEX_BITS   = 12,
    parameter int COUNTER_BITS = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [FUNC_W-1:0] func,
    input  logic [ADDR_W-1:0] br_addr,
    input  logic              taken,
    input  logic              done,
    input  logic              prediction,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [LEN_W-1:0]  cfg_data,
    output int                mismatches,
    output int                pending,
    output int                items_seen,
    output int                taken_calls
);

    localparam logic [COUNTER_BITS-1:0] CTR_SAT = '1;
    localparam logic [COUNTER_BITS-1:0] CTR_MID = COUNTER_BITS'(1 << (COUNTER_BITS - 1));

    // Shadow copy of the predictor state
    logic [HIST_W-1:0]       ghr;
    logic [LEN_W-1:0]        hist_len;
    logic [COUNTER_BITS-1:0] pht [0:(1 << INDEX_BITS) - 1];
    logic                    expected_prediction_q [$];

    always @(posedge clk or negedge rst_n)
    begin : predict
        logic [HIST_W-1:0]     hmask;
        logic [LEN_W-1:0]      eff_len;
        logic [INDEX_BITS-1:0] idx;
        logic                  want;
        logic                  oldest;
        if (!rst_n)
        begin
            ghr      = '0;
            hist_len = HIST_LEN_RESET;
            foreach (pht[i])
                pht[i] = '0;
            expected_prediction_q.delete();
            pending  = 0;
        end
        else
        begin
            // Compare the result strobe against the oldest expectation
            if (done)
            begin
                if (expected_prediction_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] result with no item waiting: prediction=%0b",
                                 $realtime, prediction);
                end
                else
                begin
                    oldest = expected_prediction_q.pop_front();
                    if (prediction !== oldest)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("[%0t] prediction mismatch: expected %0b, got %0b",
                                     $realtime, oldest, prediction);
                    end
                end
            end

            // Advance the shadow state on each accepted item
            if (start && !busy)
            begin
                eff_len = (hist_len > HIST_LEN_MAX) ? HIST_LEN_MAX : hist_len;
                hmask   = HIST_W'((32'd1 << eff_len) - 32'd1);
                idx     = br_addr[INDEX_BITS-1:0] ^ INDEX_BITS'(ghr & hmask);
                want    = 1'b0;
                case (func)
                    FUNC_LOOKUP:
                        want = (pht[idx] >= CTR_MID);
                    FUNC_UPDATE:
                    begin
                        if (taken && pht[idx] != CTR_SAT)
                            pht[idx] = pht[idx] + 1'b1;
                        else if (!taken && pht[idx] != '0)
                            pht[idx] = pht[idx] - 1'b1;
                        ghr = ((ghr << 1) | HIST_W'(taken)) & hmask;
                    end
                    FUNC_UNCOND:
                        ghr = ((ghr << 1) | HIST_W'(taken)) & hmask;
                    FUNC_BTB_UPD:
                        ghr = (ghr << 1) & hmask;
                    FUNC_SQUASH:
                        ghr = '0;
                    default:
                        ;
                endcase
                expected_prediction_q.push_back(want);
                items_seen++;
                if (want)
                    taken_calls++;
            end

            // Latch the history length on a register write
            if (cfg_valid && cfg_ready)
                hist_len = cfg_data;

            pending = expected_prediction_q.size();
        end
    end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import gsbp_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_RSVD_LO  = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_RSVD_MID = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_RSVD_HI  = 3'd7;
    localparam logic [LEN_W-1:0]  LEN_TOP       = 4'd15;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [FUNC_W-1:0] func = '0;
    logic [ADDR_W-1:0] br_addr = '0;
    logic              taken = 1'b0;
    logic              done;
    logic              prediction;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [LEN_W-1:0]  cfg_data = '0;

    int mismatches;
    int pending;
    int items_seen;
    int taken_calls;
    int idle_pct = 21;
    int cfg_writes = 0;
    int drains = 0;

    always #1 clk = ~clk;

    global_history_branch_predictor dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .br_addr    (br_addr),
        .taken      (taken),
        .done       (done),
        .prediction (prediction),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    gshare_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .br_addr     (br_addr),
        .taken       (taken),
        .done        (done),
        .prediction  (prediction),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .pending     (pending),
        .items_seen  (items_seen),
        .taken_calls (taken_calls)
    );

    // Present one item, with random idle cycles ahead of it, and hold until accepted
    task automatic send_item(input logic [FUNC_W-1:0] f, input logic [ADDR_W-1:0] a,
                             input logic t);
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start   <= 1'b1;
        func    <= f;
        br_addr <= a;
        taken   <= t;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Drop start and hold until every expected result has come
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        drains++;
    endtask

    task automatic write_hist_len(input logic [LEN_W-1:0] len);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    initial
    begin
        #400000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        logic [LEN_W-1:0]  lens [12];
        logic [ADDR_W-1:0] hot_addr [8];
        logic [FUNC_W-1:0] f;
        logic [ADDR_W-1:0] a;
        logic              t;
        int                pick;
        int                slot;
        int                waited;

        lens = '{4'd0, HIST_LEN_MAX, LEN_TOP, 4'd5, 4'd1, 4'd11,
                 4'd13, 4'd3, 4'd8, 4'd14, 4'd2, HIST_LEN_RESET};

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: cleared table at reset length, address extremes
        send_item(FUNC_LOOKUP, 32'h0000_0000, 1'b1);
        send_item(FUNC_LOOKUP, 32'hFFFF_FFFF, 1'b0);

        // Zero history: saturate one counter up, then down, at a fixed index
        drain();
        write_hist_len(4'd0);
        repeat (4) send_item(FUNC_UPDATE, 32'h0000_0005, 1'b1);
        send_item(FUNC_LOOKUP, 32'hABCD_E005, 1'b0);
        repeat (4) send_item(FUNC_UPDATE, 32'h0000_0005, 1'b0);
        send_item(FUNC_LOOKUP, 32'h0000_0005, 1'b1);
        send_item(FUNC_UNCOND, 32'hFFFF_FFFF, 1'b1);
        send_item(FUNC_BTB_UPD, 32'h0000_0005, 1'b1);
        send_item(FUNC_SQUASH, 32'h0000_0005, 1'b1);
        send_item(FUNC_RSVD_LO, 32'hFFFF_FFFF, 1'b1);
        send_item(FUNC_RSVD_MID, 32'h0000_0005, 1'b0);
        send_item(FUNC_RSVD_HI, 32'h5555_AAAA, 1'b1);

        // Long history: a length above the register width acts as the full width
        drain();
        write_hist_len(LEN_TOP);
        send_item(FUNC_UPDATE, 32'h0000_0FFF, 1'b1);
        send_item(FUNC_UNCOND, 32'h0000_0000, 1'b1);
        send_item(FUNC_UPDATE, 32'h0000_0FFC, 1'b1);
        send_item(FUNC_LOOKUP, 32'h0000_0FF8, 1'b0);
        send_item(FUNC_SQUASH, 32'h0000_0000, 1'b0);
        send_item(FUNC_LOOKUP, 32'h0000_0FFF, 1'b0);

        // Random: a small pool of hot branches with biased outcomes, plus noise
        foreach (hot_addr[i])
            hot_addr[i] = $urandom;
        for (int blk = 0; blk < 12; blk++)
        begin
            idle_pct = (blk < 4) ? 21 : (blk < 8) ? 78 : 0;
            drain();
            write_hist_len(lens[blk]);
            for (int n = 0; n < 42; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 40)
                    f = FUNC_LOOKUP;
                else if (pick < 75)
                    f = FUNC_UPDATE;
                else if (pick < 83)
                    f = FUNC_UNCOND;
                else if (pick < 90)
                    f = FUNC_BTB_UPD;
                else if (pick < 95)
                    f = FUNC_SQUASH;
                else
                    f = FUNC_W'($urandom_range(FUNC_RSVD_LO, FUNC_RSVD_HI));
                slot = $urandom_range(7);
                if ($urandom_range(99) < 70)
                    a = hot_addr[slot];
                else
                    a = $urandom;
                t = ($urandom_range(99) < 80) ^ slot[0];
                send_item(f, a, t);
                if ($urandom_range(99) < 3)
                    drain();
            end
        end

        // Hold for the tail of results, with a limit
        @(negedge clk);
        start <= 1'b0;
        waited = 0;
        while (pending != 0 && waited < 1000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (pending != 0)
            $display("%0d expected results never came", pending);

        $display("Sent %0d items (%0d predicted taken) over %0d history length writes,",
                 items_seen, taken_calls, cfg_writes);
        $display("sender idle at 21%%, 78%% and 0%%, %0d pauses until empty.", drains);
        if (mismatches == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/gsbp_pkg.sv
hw/rtl/gsbp_history.sv
hw/rtl/gsbp_counter_table.sv
hw/rtl/global_history_branch_predictor.sv
dv/gshare_checker.sv
dv/testbench.sv
